>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/scc_pkg.sv
// Types, codes and constants of the size class chunk cache.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int unsigned MaxChunks      = 16;
  localparam int unsigned NumPoolClasses = 11;
  localparam int unsigned IdxW           = $clog2(MaxChunks);
  localparam int unsigned CntW           = $clog2(MaxChunks + 1);

  localparam logic [31:0] PoolBaseSize = 32'd16;
  localparam logic [8:0]  ChunkTag     = 9'd256;
  localparam logic [15:0] DelayReset   = 16'd8000;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_POOL_ALLOC  = 4'd0,
    ST_REUSED      = 4'd1,
    ST_NEW_CHUNK   = 4'd2,
    ST_TABLE_FULL  = 4'd3,
    ST_POOL_FREE   = 4'd4,
    ST_CHUNK_FREED = 4'd5,
    ST_NOT_FOUND   = 4'd6,
    ST_BAD_POOL    = 4'd7,
    ST_TICK        = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] size;
    logic [15:0] countdown;
    logic [15:0] ident;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  pool_class;
    logic [15:0] chunk_handle;
    logic [4:0]  expired_count;
    logic [4:0]  live_chunks;
  } result_t;

endpackage

>>> rtl/core/scc_req_if.sv
// Request channel interface of the chunk cache.
// Depends on nothing but valid/ready handshake conventions.
`timescale 1ns / 1ps

interface scc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] request_size;
  logic [8:0]  pool_tag;
  logic [15:0] chunk_id;
  logic [15:0] elapsed_ms;

  modport source (output valid, operation, request_size, pool_tag, chunk_id, elapsed_ms,
                  input ready);
  modport sink (input valid, operation, request_size, pool_tag, chunk_id, elapsed_ms,
                output ready);
endinterface

>>> rtl/core/scc_rsp_if.sv
// Result channel interface of the chunk cache.
// Depends on nothing but valid/ready handshake conventions.
`timescale 1ns / 1ps

interface scc_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [3:0]  pool_class;
  logic [15:0] chunk_handle;
  logic [4:0]  expired_count;
  logic [4:0]  live_chunks;

  modport source (output valid, status, pool_class, chunk_handle, expired_count,
                  live_chunks, input ready);
  modport sink (input valid, status, pool_class, chunk_handle, expired_count,
                live_chunks, output ready);
endinterface

>>> rtl/core/size_class_chunk_cache_unit.sv
// Size class router with a table of big chunks whose release is delayed.
// Uses scc_pkg, scc_req_if and scc_rsp_if.
//
// Requests arrive on req_i (valid/ready), one result per request leaves on rsp_o.
// A request is taken only while the unit is idle. Pool allocations, pool frees,
// bad tags and the unused opcode go via res_q to the output register, with no walk.
// Chunk allocate, chunk free and tick walk the chunk table through a one-port
// read / one-port write memory, one slot per cycle through a registered read;
// the walk stops at a hit or after the last filled slot, of 16 at most.
// A finished result sits in the output register; the next request is accepted
// as soon as the result has been moved there, even while rsp_o is stalled.
// If the output register is still full when a result is ready, the unit waits.
// Reset empties the table, clears the id counter and loads the release delay
// with 8000 ms; no clearing pass is needed since table occupancy is a fill count.
// cfg_we_i/cfg_wdata_i write the release delay; write it only while idle.
`timescale 1ns / 1ps

module size_class_chunk_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  scc_req_if.sink     req_i,
  scc_rsp_if.source   rsp_o
);

  localparam int unsigned IdxW = scc_pkg::IdxW;
  localparam int unsigned CntW = scc_pkg::CntW;

  scc_pkg::entry_t mem_q [scc_pkg::MaxChunks];

  scc_pkg::state_e  state_q, state_d;
  logic [15:0]      delay_q;
  logic [15:0]      next_id_q, next_id_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  live_q, live_d;
  logic [scc_pkg::MaxChunks-1:0] rel_q, rel_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  kept_q, kept_d;
  logic [CntW-1:0]  removed_q, removed_d;
  logic             rvld_q, rvld_d;
  logic [IdxW-1:0]  pidx_q;
  scc_pkg::entry_t  rd_q;

  scc_pkg::op_e     op_q;
  logic [31:0]      size_q;
  logic [15:0]      id_q;
  logic [15:0]      elapsed_q;

  scc_pkg::result_t res_q, res_d;
  scc_pkg::result_t out_q;
  logic             out_v_q;

  logic             accept, issue, hit, scan_end, finish;
  logic             is_pool;
  logic [3:0]       pool_k;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  scc_pkg::entry_t  mem_wdata;
  logic [15:0]      cd_sat;
  logic             rel_p;

  assign accept = req_i.valid && req_i.ready;
  assign issue  = (state_q == scc_pkg::S_SCAN) && (idx_q < cnt_q) && !hit;
  assign rel_p  = rel_q[pidx_q];
  assign cd_sat = (rd_q.countdown > elapsed_q) ? (rd_q.countdown - elapsed_q) : 16'd0;

  always_comb begin
    pool_k = 4'd0;
    for (int k = scc_pkg::NumPoolClasses - 1; k >= 0; k--) begin
      if (req_i.request_size < (scc_pkg::PoolBaseSize << k)) begin
        pool_k = 4'(k);
      end
    end
    is_pool = req_i.request_size <
              (scc_pkg::PoolBaseSize << (scc_pkg::NumPoolClasses - 1));
  end

  // control
  always_comb begin
    hit = 1'b0;
    if ((state_q == scc_pkg::S_SCAN) && rvld_q) begin
      if (op_q == scc_pkg::OP_ALLOC) begin
        hit = rel_p && (rd_q.countdown != 16'd0) && (rd_q.size >= size_q) &&
              ({1'b0, rd_q.size} < {size_q, 1'b0});
      end else if (op_q == scc_pkg::OP_FREE) begin
        hit = rd_q.ident == id_q;
      end
    end
    scan_end = (state_q == scc_pkg::S_SCAN) && !rvld_q && !(idx_q < cnt_q);
    finish   = hit || scan_end;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scc_pkg::S_IDLE: begin
        if (accept) begin
          if ((req_i.operation == scc_pkg::OP_TICK) ||
              ((req_i.operation == scc_pkg::OP_ALLOC) && !is_pool) ||
              ((req_i.operation == scc_pkg::OP_FREE) &&
               (req_i.pool_tag == scc_pkg::ChunkTag))) begin
            state_d = scc_pkg::S_SCAN;
          end else begin
            state_d = scc_pkg::S_DONE;
          end
        end
      end
      scc_pkg::S_SCAN: begin
        if (finish) begin
          state_d = scc_pkg::S_DONE;
        end
      end
      scc_pkg::S_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          state_d = scc_pkg::S_IDLE;
        end
      end
      default: state_d = scc_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    res_d     = res_q;
    next_id_d = next_id_q;
    cnt_d     = cnt_q;
    live_d    = live_q;
    rel_d     = rel_q;
    idx_d     = idx_q;
    kept_d    = kept_q;
    removed_d = removed_q;
    rvld_d    = issue;
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = rd_q;
    if (issue) begin
      idx_d = idx_q + 1'b1;
    end
    if (state_q == scc_pkg::S_IDLE && accept) begin
      idx_d     = '0;
      kept_d    = '0;
      removed_d = '0;
      res_d     = '{status: scc_pkg::ST_TICK, pool_class: 4'd0, chunk_handle: 16'd0,
                    expired_count: 5'd0, live_chunks: 5'(live_q)};
      case (req_i.operation)
        scc_pkg::OP_ALLOC: begin
          res_d.status     = scc_pkg::ST_POOL_ALLOC;
          res_d.pool_class = pool_k;
        end
        scc_pkg::OP_FREE: begin
          if (req_i.pool_tag < 9'(scc_pkg::NumPoolClasses)) begin
            res_d.status     = scc_pkg::ST_POOL_FREE;
            res_d.pool_class = req_i.pool_tag[3:0];
          end else begin
            res_d.status = scc_pkg::ST_BAD_POOL;
          end
        end
        default: res_d.status = scc_pkg::ST_TICK;
      endcase
    end
    if (state_q == scc_pkg::S_SCAN) begin
      if (rvld_q) begin
        case (op_q)
          scc_pkg::OP_ALLOC: begin
            if (hit) begin
              rel_d[pidx_q]      = 1'b0;
              live_d             = live_q + 1'b1;
              res_d.status       = scc_pkg::ST_REUSED;
              res_d.chunk_handle = rd_q.ident;
            end
          end
          scc_pkg::OP_FREE: begin
            if (hit) begin
              rel_d[pidx_q]   = 1'b1;
              mem_we          = 1'b1;
              mem_wdata.countdown = delay_q;
              if (!rel_p) begin
                live_d = live_q - 1'b1;
              end
              res_d.status = scc_pkg::ST_CHUNK_FREED;
            end
          end
          default: begin
            if (rel_p && (cd_sat == 16'd0)) begin
              removed_d = removed_q + 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = kept_q[IdxW-1:0];
              if (rel_p) begin
                mem_wdata.countdown = cd_sat;
              end
              rel_d[kept_q[IdxW-1:0]] = rel_p;
              kept_d = kept_q + 1'b1;
            end
          end
        endcase
      end else if (scan_end) begin
        case (op_q)
          scc_pkg::OP_ALLOC: begin
            if (cnt_q == CntW'(scc_pkg::MaxChunks)) begin
              res_d.status = scc_pkg::ST_TABLE_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[IdxW-1:0];
              mem_wdata = '{size: size_q, countdown: 16'd0, ident: next_id_q};
              rel_d[cnt_q[IdxW-1:0]] = 1'b0;
              cnt_d              = cnt_q + 1'b1;
              live_d             = live_q + 1'b1;
              next_id_d          = next_id_q + 16'd1;
              res_d.status       = scc_pkg::ST_NEW_CHUNK;
              res_d.chunk_handle = next_id_q;
            end
          end
          scc_pkg::OP_FREE: res_d.status = scc_pkg::ST_NOT_FOUND;
          default: begin
            cnt_d = kept_q;
            for (int i = 0; i < scc_pkg::MaxChunks; i++) begin
              if (CntW'(i) >= kept_q) begin
                rel_d[i] = 1'b0;
              end
            end
            res_d.status        = scc_pkg::ST_TICK;
            res_d.expired_count = 5'(removed_q);
          end
        endcase
      end
      if (finish) begin
        res_d.live_chunks = 5'(live_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q   <= mem_q[idx_q[IdxW-1:0]];
      pidx_q <= idx_q[IdxW-1:0];
    end
    if (accept) begin
      op_q      <= scc_pkg::op_e'(req_i.operation);
      size_q    <= req_i.request_size;
      id_q      <= req_i.chunk_id;
      elapsed_q <= req_i.elapsed_ms;
    end
    res_q <= res_d;
    if ((state_q == scc_pkg::S_DONE) && (!out_v_q || rsp_o.ready)) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scc_pkg::S_IDLE;
      delay_q   <= scc_pkg::DelayReset;
      next_id_q <= '0;
      cnt_q     <= '0;
      live_q    <= '0;
      rel_q     <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      removed_q <= '0;
      rvld_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      cnt_q     <= cnt_d;
      live_q    <= live_d;
      rel_q     <= rel_d;
      idx_q     <= idx_d;
      kept_q    <= kept_d;
      removed_q <= removed_d;
      rvld_q    <= rvld_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if ((state_q == scc_pkg::S_DONE) && (!out_v_q || rsp_o.ready)) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign req_i.ready         = (state_q == scc_pkg::S_IDLE);
  assign rsp_o.valid         = out_v_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.pool_class    = out_q.pool_class;
  assign rsp_o.chunk_handle  = out_q.chunk_handle;
  assign rsp_o.expired_count = out_q.expired_count;
  assign rsp_o.live_chunks   = out_q.live_chunks;

endmodule

>>> rtl/core/scc_checker.sv
// Port-level checks of the chunk cache, bound to the top level.
// Uses scc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  status_i,
  input logic [3:0]  pool_class_i,
  input logic [4:0]  expired_count_i,
  input logic [4:0]  live_chunks_i
);

  `SCC_ASSERT(a_one_at_a_time, in_valid_i && in_ready_i |=> !in_ready_i)
  `SCC_ASSERT(a_rsp_holds, out_valid_i && !out_ready_i |=> out_valid_i)
  `SCC_ASSERT(a_pool_range, out_valid_i && (status_i == scc_pkg::ST_POOL_ALLOC) |-> pool_class_i < 4'(scc_pkg::NumPoolClasses))
  `SCC_ASSERT(a_expired_tick_only, out_valid_i && (status_i != scc_pkg::ST_TICK) |-> expired_count_i == 5'd0)
  `SCC_ASSERT(a_live_after_alloc, out_valid_i && ((status_i == scc_pkg::ST_REUSED) || (status_i == scc_pkg::ST_NEW_CHUNK)) |-> live_chunks_i != 5'd0)

endmodule

bind size_class_chunk_cache_unit scc_checker u_scc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .pool_class_i    (rsp_o.pool_class),
  .expired_count_i (rsp_o.expired_count),
  .live_chunks_i   (rsp_o.live_chunks)
);
